// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHECK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Check an implication in the next cycle.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

// ===== rtl/mcpb_pkg.sv =====
// Shared codes for the pipe buffer unit.
package mcpb_pkg;
   localparam logic [1:0] KIND_OPEN  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ERR   = 2'd1;
   localparam logic [1:0] STAT_BLOCK = 2'd2;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_BLOCK = 2'd1;
   localparam logic [1:0] EV_WAKE  = 2'd2;

   localparam logic [5:0]  FD_BASE = 6'd3;
   localparam logic [15:0] NO_PID  = 16'hFFFF;

   typedef logic [1:0] kind_type;
endpackage

// ===== rtl/multi_channel_pipe_buffer_unit.sv =====
// Top level of the multi-channel pipe buffer unit.
//
// Requests arrive on req_* (valid/ready) and each gives exactly one response
// word on rsp_* (valid/ready). Open, close, byte write and byte read are the
// request kinds; the response carries status, returned fd, read data, a
// block/wake event with its pid, and an echo of last_of_transfer.
// One request is handled at a time by a small sequencer. Close, write and
// read pass through ST_EXEC (decode with the byte memory access) and ST_MEM
// (for the registered read byte) before raising rsp_valid. Open walks the
// slot table with one shared compare, one slot per cycle, first in ST_SCAN1
// for a slot to pair with, then in ST_SCAN2 for a free one, and then raises
// rsp_valid. req_ready returns the cycle after the response is accepted.
// The byte memory holds NUM_SLOTS rings of 2**PW bytes, with one write and
// one registered read per cycle, in ST_EXEC only.
// A response waits in its output register while the receiver stalls; no new
// request is taken until it is accepted.
// Reset clears all slot state at once (flags, positions, ids) in
// per-slot registers; the byte memory is not cleared and needs no pass.
module multi_channel_pipe_buffer_unit #(
   parameter int NUM_SLOTS  = 32,
   parameter int SLOT_DEPTH = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [14:0]        req_pid,
   input  logic               req_mode,
   input  logic [5:0]         req_fd,
   input  logic [7:0]         req_data_in,
   input  logic               req_last_of_transfer,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_fd_out,
   output logic [7:0]         rsp_data_out,
   output logic [1:0]         rsp_event_res,
   output logic signed [15:0] rsp_event_pid,
   output logic               rsp_last
);
`include "assert_macros.svh"

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PW = $clog2(SLOT_DEPTH);
   localparam int CW = $clog2(SLOT_DEPTH + 1);
   localparam int OW = $clog2(NUM_SLOTS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN1 = 3'd1;
   localparam logic [2:0] ST_SCAN2 = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_MEM   = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff;
   logic [14:0] pid_ff;
   logic mode_ff, last_ff;
   logic [5:0] fd_ff;
   logic [7:0] data_ff;
   logic [SW:0] idx_ff;   // scan index, wide enough to hold NUM_SLOTS

   logic [PW-1:0] rpos_ff [NUM_SLOTS];
   logic [PW-1:0] wpos_ff [NUM_SLOTS];
   logic [CW-1:0] fill_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] use_ff, rwait_ff, wwait_ff;
   logic [15:0] rid_ff [NUM_SLOTS];
   logic [15:0] wid_ff [NUM_SLOTS];
   logic [OW-1:0] open_cnt_ff;

   logic [7:0] mem [NUM_SLOTS * (2**PW)];
   logic [7:0] rdata_ff;
   logic mem_rd_ff;

   logic [1:0] st_ff;
   logic [5:0] fdo_ff;
   logic [1:0] ev_ff;
   logic [15:0] evp_ff;

   logic req_fire, fd_ok, scan_hit, scan_free;
   logic [SW-1:0] cur;
   logic [5:0] fd_rel;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign cur       = idx_ff[SW-1:0];
   assign fd_rel    = fd_ff - mcpb_pkg::FD_BASE;
   assign fd_ok     = (fd_ff >= mcpb_pkg::FD_BASE) &&
                      (int'(fd_ff) < NUM_SLOTS + int'(mcpb_pkg::FD_BASE));
   assign scan_hit  = use_ff[cur] &&
                      (mode_ff ? (rid_ff[cur] != mcpb_pkg::NO_PID)
                               : (wid_ff[cur] != mcpb_pkg::NO_PID));
   assign scan_free = !use_ff[cur];

   assign rsp_valid     = (state_ff == ST_RESP);
   assign rsp_status    = st_ff;
   assign rsp_fd_out    = fdo_ff;
   assign rsp_data_out  = mem_rd_ff ? rdata_ff : 8'd0;
   assign rsp_event_res = ev_ff;
   assign rsp_event_pid = evp_ff;
   assign rsp_last      = last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) begin
            state_in = (req_kind == mcpb_pkg::KIND_OPEN) ? ST_SCAN1 : ST_EXEC;
         end
         ST_SCAN1: begin
            if (int'(open_cnt_ff) >= NUM_SLOTS) state_in = ST_RESP;
            else if (scan_hit) state_in = ST_RESP;
            else if (int'(idx_ff) == NUM_SLOTS - 1) state_in = ST_SCAN2;
         end
         ST_SCAN2: if (scan_free || int'(idx_ff) == NUM_SLOTS - 1) state_in = ST_RESP;
         ST_EXEC:  state_in = ST_MEM;
         ST_MEM:   state_in = ST_RESP;
         ST_RESP:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // byte memory: accessed only in ST_EXEC, one write and one read per request
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && fd_ok) begin
         if (kind_ff == mcpb_pkg::KIND_WRITE && int'(fill_ff[fd_rel[SW-1:0]]) < SLOT_DEPTH)
            mem[{fd_rel[SW-1:0], wpos_ff[fd_rel[SW-1:0]]}] <= data_ff;
         rdata_ff <= mem[{fd_rel[SW-1:0], rpos_ff[fd_rel[SW-1:0]]}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         use_ff      <= '0;
         rwait_ff    <= '0;
         wwait_ff    <= '0;
         open_cnt_ff <= '0;
         idx_ff      <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            rpos_ff[i] <= '0;
            wpos_ff[i] <= '0;
            fill_ff[i] <= '0;
            rid_ff[i]  <= mcpb_pkg::NO_PID;
            wid_ff[i]  <= mcpb_pkg::NO_PID;
         end
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (req_fire) begin
               kind_ff   <= req_kind;
               pid_ff    <= req_pid;
               mode_ff   <= req_mode;
               fd_ff     <= req_fd;
               data_ff   <= req_data_in;
               last_ff   <= req_last_of_transfer;
               idx_ff    <= '0;
               st_ff     <= mcpb_pkg::STAT_OK;
               fdo_ff    <= '0;
               ev_ff     <= mcpb_pkg::EV_NONE;
               evp_ff    <= '0;
               mem_rd_ff <= 1'b0;
            end
            ST_SCAN1: begin
               if (int'(open_cnt_ff) >= NUM_SLOTS) begin
                  st_ff <= mcpb_pkg::STAT_ERR;
               end else if (scan_hit) begin
                  if (mode_ff) wid_ff[cur] <= {1'b0, pid_ff};
                  else rid_ff[cur] <= {1'b0, pid_ff};
                  fdo_ff <= 6'(idx_ff) + mcpb_pkg::FD_BASE;
               end else if (int'(idx_ff) == NUM_SLOTS - 1) begin
                  idx_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_SCAN2: begin
               if (scan_free) begin
                  rpos_ff[cur]  <= '0;
                  wpos_ff[cur]  <= '0;
                  fill_ff[cur]  <= '0;
                  rwait_ff[cur] <= 1'b0;
                  wwait_ff[cur] <= 1'b0;
                  rid_ff[cur]   <= mode_ff ? mcpb_pkg::NO_PID : {1'b0, pid_ff};
                  wid_ff[cur]   <= mode_ff ? {1'b0, pid_ff} : mcpb_pkg::NO_PID;
                  use_ff[cur]   <= 1'b1;
                  open_cnt_ff   <= open_cnt_ff + 1'b1;
                  fdo_ff        <= 6'(idx_ff) + mcpb_pkg::FD_BASE;
               end else if (int'(idx_ff) == NUM_SLOTS - 1) begin
                  st_ff <= mcpb_pkg::STAT_ERR;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_EXEC: begin
               if (!fd_ok) begin
                  st_ff <= mcpb_pkg::STAT_ERR;
               end else begin
                  case (kind_ff)
                     mcpb_pkg::KIND_CLOSE: begin
                        if (rid_ff[fd_rel[SW-1:0]] == mcpb_pkg::NO_PID &&
                            wid_ff[fd_rel[SW-1:0]] == mcpb_pkg::NO_PID) begin
                           st_ff <= mcpb_pkg::STAT_ERR;
                        end else begin
                           rid_ff[fd_rel[SW-1:0]]  <= mcpb_pkg::NO_PID;
                           wid_ff[fd_rel[SW-1:0]]  <= mcpb_pkg::NO_PID;
                           use_ff[fd_rel[SW-1:0]]  <= 1'b0;
                           rpos_ff[fd_rel[SW-1:0]] <= '0;
                           wpos_ff[fd_rel[SW-1:0]] <= '0;
                           fill_ff[fd_rel[SW-1:0]] <= '0;
                           if (open_cnt_ff != '0) open_cnt_ff <= open_cnt_ff - 1'b1;
                        end
                     end
                     mcpb_pkg::KIND_WRITE: begin
                        if (int'(fill_ff[fd_rel[SW-1:0]]) >= SLOT_DEPTH) begin
                           wwait_ff[fd_rel[SW-1:0]] <= 1'b1;
                           st_ff  <= mcpb_pkg::STAT_BLOCK;
                           ev_ff  <= mcpb_pkg::EV_BLOCK;
                           evp_ff <= wid_ff[fd_rel[SW-1:0]];
                        end else begin
                           // wrap the ring at SLOT_DEPTH
                           if (int'(wpos_ff[fd_rel[SW-1:0]]) == SLOT_DEPTH - 1)
                              wpos_ff[fd_rel[SW-1:0]] <= '0;
                           else
                              wpos_ff[fd_rel[SW-1:0]] <= wpos_ff[fd_rel[SW-1:0]] + 1'b1;
                           fill_ff[fd_rel[SW-1:0]] <= fill_ff[fd_rel[SW-1:0]] + 1'b1;
                           if (rwait_ff[fd_rel[SW-1:0]]) begin
                              rwait_ff[fd_rel[SW-1:0]] <= 1'b0;
                              ev_ff  <= mcpb_pkg::EV_WAKE;
                              evp_ff <= rid_ff[fd_rel[SW-1:0]];
                           end
                        end
                     end
                     mcpb_pkg::KIND_READ: begin
                        if (fill_ff[fd_rel[SW-1:0]] == '0) begin
                           rwait_ff[fd_rel[SW-1:0]] <= 1'b1;
                           st_ff  <= mcpb_pkg::STAT_BLOCK;
                           ev_ff  <= mcpb_pkg::EV_BLOCK;
                           evp_ff <= rid_ff[fd_rel[SW-1:0]];
                        end else begin
                           mem_rd_ff <= 1'b1;
                           if (int'(rpos_ff[fd_rel[SW-1:0]]) == SLOT_DEPTH - 1)
                              rpos_ff[fd_rel[SW-1:0]] <= '0;
                           else
                              rpos_ff[fd_rel[SW-1:0]] <= rpos_ff[fd_rel[SW-1:0]] + 1'b1;
                           fill_ff[fd_rel[SW-1:0]] <= fill_ff[fd_rel[SW-1:0]] - 1'b1;
                           if (wwait_ff[fd_rel[SW-1:0]]) begin
                              wwait_ff[fd_rel[SW-1:0]] <= 1'b0;
                              ev_ff  <= mcpb_pkg::EV_WAKE;
                              evp_ff <= wid_ff[fd_rel[SW-1:0]];
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   `CHECK_IMPL(a_ready_idle, clock, reset, req_ready, !rsp_valid)
   `CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
   `CHECK_IMPL(a_block_stat, clock, reset, rsp_valid && rsp_event_res == mcpb_pkg::EV_BLOCK,
               rsp_status == mcpb_pkg::STAT_BLOCK)
endmodule

// ===== tb/multi_channel_pipe_buffer_unit_tb.sv =====
// Self-checking bench for the pipe buffer unit: directed and random requests, predicted responses.
module multi_channel_pipe_buffer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 32;
   localparam int DEPTH = 512;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [14:0] pid;
      logic        mode;
      logic [5:0]  fd;
      logic [7:0]  data;
      logic        last;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         fd_out;
      logic [7:0]         data_out;
      logic [1:0]         ev;
      logic signed [15:0] ev_pid;
      logic               last;
   } rsp_word_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_kind;
   logic [14:0] req_pid;
   logic req_mode;
   logic [5:0] req_fd;
   logic [7:0] req_data_in;
   logic req_last_of_transfer;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_status;
   logic [5:0] rsp_fd_out;
   logic [7:0] rsp_data_out;
   logic [1:0] rsp_event_res;
   logic signed [15:0] rsp_event_pid;
   logic rsp_last;

   multi_channel_pipe_buffer_unit #(.NUM_SLOTS(SLOTS), .SLOT_DEPTH(DEPTH)) dut (.*);

   // pipe table mirror
   logic [7:0]  pipe_bytes [SLOTS*DEPTH];
   int          rd_pos [SLOTS];
   int          wr_pos [SLOTS];
   int          fill [SLOTS];
   bit          busy [SLOTS];
   logic [15:0] rd_owner [SLOTS];
   logic [15:0] wr_owner [SLOTS];
   bit          rd_wait [SLOTS];
   bit          wr_wait [SLOTS];
   int          opened;

   req_word_type pending_reqs[$];
   rsp_word_type expected_rsps[$];
   int  errors = 0;
   bit  stim_done = 0;
   bit  calm = 0;        // no idling in the final part
   bit  hold_off = 0;    // long receiver stall request
   int  send_gap = 0, recv_gap = 0, hold_cnt = 0, idle_cycles = 0;

   function automatic rsp_word_type predict_pipe_op(req_word_type r);
      rsp_word_type o;
      int s, i;
      o = '0;
      o.last = r.last;
      if (r.kind == mcpb_pkg::KIND_OPEN) begin
         if (opened >= SLOTS) begin
            o.status = mcpb_pkg::STAT_ERR;
            return o;
         end
         for (i = 0; i < SLOTS; i++) begin
            if (!busy[i]) continue;
            if (r.mode == 1'b0 && wr_owner[i] != mcpb_pkg::NO_PID) begin
               rd_owner[i] = {1'b0, r.pid};
               o.fd_out = 6'(i) + mcpb_pkg::FD_BASE;
               return o;
            end
            if (r.mode == 1'b1 && rd_owner[i] != mcpb_pkg::NO_PID) begin
               wr_owner[i] = {1'b0, r.pid};
               o.fd_out = 6'(i) + mcpb_pkg::FD_BASE;
               return o;
            end
         end
         for (i = 0; i < SLOTS; i++) if (!busy[i]) break;
         if (i >= SLOTS) begin
            o.status = mcpb_pkg::STAT_ERR;
            return o;
         end
         rd_pos[i] = 0; wr_pos[i] = 0; fill[i] = 0;
         rd_wait[i] = 0; wr_wait[i] = 0;
         rd_owner[i] = r.mode ? mcpb_pkg::NO_PID : {1'b0, r.pid};
         wr_owner[i] = r.mode ? {1'b0, r.pid} : mcpb_pkg::NO_PID;
         busy[i] = 1;
         opened++;
         o.fd_out = 6'(i) + mcpb_pkg::FD_BASE;
         return o;
      end
      if (r.fd < mcpb_pkg::FD_BASE || int'(r.fd) >= SLOTS + int'(mcpb_pkg::FD_BASE)) begin
         o.status = mcpb_pkg::STAT_ERR;
         return o;
      end
      s = int'(r.fd) - int'(mcpb_pkg::FD_BASE);
      case (r.kind)
         mcpb_pkg::KIND_CLOSE: begin
            if (rd_owner[s] == mcpb_pkg::NO_PID && wr_owner[s] == mcpb_pkg::NO_PID)
               o.status = mcpb_pkg::STAT_ERR;
            else begin
               rd_owner[s] = mcpb_pkg::NO_PID; wr_owner[s] = mcpb_pkg::NO_PID; busy[s] = 0;
               rd_pos[s] = 0; wr_pos[s] = 0; fill[s] = 0;
               if (opened > 0) opened--;
            end
         end
         mcpb_pkg::KIND_WRITE: begin
            if (fill[s] >= DEPTH) begin
               wr_wait[s] = 1;
               o.status = mcpb_pkg::STAT_BLOCK; o.ev = mcpb_pkg::EV_BLOCK;
               o.ev_pid = wr_owner[s];
            end else begin
               pipe_bytes[s*DEPTH + wr_pos[s]] = r.data;
               wr_pos[s] = (wr_pos[s] + 1) % DEPTH;
               fill[s]++;
               if (rd_wait[s]) begin
                  rd_wait[s] = 0;
                  o.ev = mcpb_pkg::EV_WAKE; o.ev_pid = rd_owner[s];
               end
            end
         end
         default: begin
            if (fill[s] == 0) begin
               rd_wait[s] = 1;
               o.status = mcpb_pkg::STAT_BLOCK; o.ev = mcpb_pkg::EV_BLOCK;
               o.ev_pid = rd_owner[s];
            end else begin
               o.data_out = pipe_bytes[s*DEPTH + rd_pos[s]];
               rd_pos[s] = (rd_pos[s] + 1) % DEPTH;
               fill[s]--;
               if (wr_wait[s]) begin
                  wr_wait[s] = 0;
                  o.ev = mcpb_pkg::EV_WAKE; o.ev_pid = wr_owner[s];
               end
            end
         end
      endcase
      return o;
   endfunction

   function automatic req_word_type mk(logic [1:0] k, logic [14:0] p, logic m,
                                       logic [5:0] f, logic [7:0] d, logic l);
      req_word_type r;
      r.kind = k; r.pid = p; r.mode = m; r.fd = f; r.data = d; r.last = l;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_kind <= '0; req_pid <= '0; req_mode <= 0; req_fd <= '0;
         req_data_in <= '0; req_last_of_transfer <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(predict_pipe_op(
               mk(req_kind, req_pid, req_mode, req_fd, req_data_in, req_last_of_transfer)));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(1, 17) - 1;
               req_valid <= 0;
            end else if (pending_reqs.size() > 0) begin
               req_word_type r;
               r = pending_reqs.pop_front();
               req_valid <= 1;
               req_kind <= r.kind; req_pid <= r.pid; req_mode <= r.mode;
               req_fd <= r.fd; req_data_in <= r.data; req_last_of_transfer <= r.last;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // receiver stall and response checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_word_type a, e;
            a.status = rsp_status; a.fd_out = rsp_fd_out; a.data_out = rsp_data_out;
            a.ev = rsp_event_res; a.ev_pid = rsp_event_pid; a.last = rsp_last;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response word %h", $time, a);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (a.status !== e.status)
                  $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
               if (a.fd_out !== e.fd_out)
                  $display("%0t: fd_out exp %0d got %0d", $time, e.fd_out, a.fd_out);
               if (a.data_out !== e.data_out)
                  $display("%0t: data_out exp %h got %h", $time, e.data_out, a.data_out);
               if (a.ev !== e.ev)
                  $display("%0t: event_res exp %0d got %0d", $time, e.ev, a.ev);
               if (a.ev_pid !== e.ev_pid)
                  $display("%0t: event_pid exp %0d got %0d", $time, e.ev_pid, a.ev_pid);
               if (a.last !== e.last)
                  $display("%0t: last exp %0d got %0d", $time, e.last, a.last);
               if (a !== e) errors++;
            end
         end
         if (hold_off && hold_cnt < 300) begin
            hold_cnt <= hold_cnt + 1;
            rsp_ready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 17) - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // watchdog: count cycles with no word accepted
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("** multi_channel_pipe_buffer_unit: FAILED **");
         $finish;
      end
   end

   task automatic add_random(int n);
      int i, j, f, len;
      logic [14:0] p;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1: pending_reqs.push_back(mk(mcpb_pkg::KIND_OPEN, 15'($urandom),
                                            1'($urandom), 6'd0, 8'($urandom),
                                            1'($urandom)));
            2: pending_reqs.push_back(mk(mcpb_pkg::KIND_CLOSE, 15'($urandom),
                                         1'($urandom), 6'($urandom_range(0, 40)),
                                         8'($urandom), 1'($urandom)));
            3: pending_reqs.push_back(mk(2'($urandom), 15'($urandom), 1'($urandom),
                                         6'($urandom), 8'($urandom), 1'($urandom)));
            default: begin
               // well-formed burst on a likely-open descriptor
               f = $urandom_range(3, 10);
               len = $urandom_range(1, 12);
               p = 15'($urandom);
               for (j = 0; j < len; j++)
                  pending_reqs.push_back(mk($urandom_range(0, 2) ? mcpb_pkg::KIND_WRITE
                                                                 : mcpb_pkg::KIND_READ,
                                            p, 1'($urandom), 6'(f), 8'($urandom),
                                            j == len - 1));
            end
         endcase
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < SLOTS; i++) begin
         rd_pos[i] = 0; wr_pos[i] = 0; fill[i] = 0; busy[i] = 0;
         rd_owner[i] = mcpb_pkg::NO_PID; wr_owner[i] = mcpb_pkg::NO_PID;
         rd_wait[i] = 0; wr_wait[i] = 0;
      end
      opened = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed: bad descriptors, unowned close, empty read, pairing, wake
      pending_reqs.push_back(mk(mcpb_pkg::KIND_CLOSE, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_WRITE, 0, 0, 2, 8'hFF, 1));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_READ, 0, 0, 35, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_READ, 0, 0, 63, 0, 1));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_CLOSE, 0, 0, 34, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_OPEN, 15'h7FFF, 0, 0, 0, 1));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_READ, 0, 0, 3, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_OPEN, 15'd0, 1, 0, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_WRITE, 0, 0, 3, 8'h00, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_WRITE, 0, 0, 3, 8'hA5, 1));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_READ, 0, 0, 3, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_READ, 0, 0, 3, 0, 1));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_WRITE, 0, 0, 4, 8'h5A, 0)); // slot not in use
      pending_reqs.push_back(mk(mcpb_pkg::KIND_READ, 0, 0, 4, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_CLOSE, 0, 0, 3, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_CLOSE, 0, 0, 3, 0, 0));
      // fill the table, then two more opens and a close on every slot
      for (i = 0; i < SLOTS; i++)
         pending_reqs.push_back(mk(mcpb_pkg::KIND_OPEN, 15'(i), 0, 0, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_OPEN, 15'd99, 1, 0, 0, 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_OPEN, 15'd98, 1, 0, 0, 0));
      for (i = 0; i < SLOTS; i++)
         pending_reqs.push_back(mk(mcpb_pkg::KIND_CLOSE, 0, 0,
                                   6'(i) + mcpb_pkg::FD_BASE, 0, 0));
      // fill one pipe to the brim: block writer, then read to wake it
      pending_reqs.push_back(mk(mcpb_pkg::KIND_OPEN, 15'd7, 1, 0, 0, 0));
      for (i = 0; i <= DEPTH; i++)
         pending_reqs.push_back(mk(mcpb_pkg::KIND_WRITE, 0, 0, 3, 8'($urandom), 0));
      pending_reqs.push_back(mk(mcpb_pkg::KIND_READ, 0, 0, 3, 0, 1));
      wait (pending_reqs.size() == 0);

      // long receiver hold-off while requests keep coming
      hold_off = 1;
      add_random(30);
      wait (pending_reqs.size() == 0 && hold_cnt >= 300);
      hold_off = 0;

      add_random(250);
      wait (pending_reqs.size() == 0);
      calm = 1;
      add_random(40);
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid || expected_rsps.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("** multi_channel_pipe_buffer_unit: PASSED **");
      else $display("** multi_channel_pipe_buffer_unit: FAILED **");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mcpb_pkg.sv
rtl/multi_channel_pipe_buffer_unit.sv
tb/multi_channel_pipe_buffer_unit_tb.sv
